>>> sv/affine_warp_sampler_unit_macros.svh
// Assertion macros used by the checker file of the affine warp sampler.
// No dependencies; included by bare file name.
`ifndef AFFINE_WARP_SAMPLER_UNIT_MACROS_SVH
`define AFFINE_WARP_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge outside reset.
`define AWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("affine warp sampler check failed");

// Next-cycle implication, sampled at the rising clock edge outside reset.
`define AWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("affine warp sampler check failed");

`endif

>>> sv/awarp_pkg.sv
// Shared constants, register codes and command types of the affine warp sampler.
// No dependencies; imported by every other file of the block but the macro header.
package awarp_pkg;

    localparam int MAX_ROWS = 512;
    localparam int MAX_COLS = 512;
    localparam int ROW_W    = ($clog2(MAX_ROWS) < 2) ? 2 : $clog2(MAX_ROWS);
    localparam int COL_W    = ($clog2(MAX_COLS) < 2) ? 2 : $clog2(MAX_COLS);
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int COLS_W   = $clog2(MAX_COLS + 1);
    localparam int BANK_AW  = (ROW_W - 1) + (COL_W - 1);

    localparam int PIX_W    = 12;
    localparam int VAL_W    = 8;
    localparam int COEF_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = PIX_W + 1 + COEF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int WGT_W    = FRAC_W + 1;
    localparam int MIX_W    = WGT_W + VAL_W + 1;

    localparam int CMD_DEPTH = 8;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_C00    = 3'd0,
        REG_C01    = 3'd1,
        REG_C10    = 3'd2,
        REG_C11    = 3'd3,
        REG_OFF_R  = 3'd4,
        REG_OFF_C  = 3'd5,
        REG_MODE   = 3'd6,
        REG_EXTENT = 3'd7
    } reg_idx_t;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef enum logic {
        MODE_NEAREST  = 1'b0,
        MODE_BILINEAR = 1'b1
    } mode_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] c00;
        logic signed [COEF_W-1:0] c01;
        logic signed [COEF_W-1:0] c10;
        logic signed [COEF_W-1:0] c11;
        logic signed [COEF_W-1:0] off_r;
        logic signed [COEF_W-1:0] off_c;
        mode_t                    mode;
        logic [ROWS_W-1:0]        rows;
        logic [COLS_W-1:0]        cols;
    } cfg_t;

    typedef struct packed {
        logic              is_write;
        logic              wr_en;
        logic              in_frame;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              clamp_r;
        logic              clamp_c;
        logic [FRAC_W-1:0] frac_r;
        logic [FRAC_W-1:0] frac_c;
        logic [VAL_W-1:0]  wr_data;
    } warp_cmd_t;

endpackage

>>> sv/awarp_if.sv
// Valid/ready channel interfaces for pixel items and sampled results.
// Depends on awarp_pkg.
interface awarp_req_if;
    import awarp_pkg::*;
    logic             valid;
    logic             ready;
    logic             func;
    logic [PIX_W-1:0] pix_row;
    logic [PIX_W-1:0] pix_col;
    logic [VAL_W-1:0] write_value;
    modport source (output valid, func, pix_row, pix_col, write_value, input ready);
    modport sink   (input valid, func, pix_row, pix_col, write_value, output ready);
endinterface

interface awarp_res_if;
    import awarp_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] out_value;
    logic             inside_res;
    modport source (output valid, out_value, inside_res, input ready);
    modport sink   (input valid, out_value, inside_res, output ready);
endinterface

>>> sv/affine_warp_sampler_unit.sv
// Throughput: one item per cycle while the command queue and the result credits have room;
// the four parity banks serve all bilinear neighbors at once.
// Reset: clears the registers to identity warp, nearest mode and a 512 x 512 extent,
// and empties both queues; the frame store is not cleared and holds nothing until written.
// Top level: APB register file, front end, command queue and back end.
// Depends on awarp_pkg, awarp_if, awarp_front, awarp_cmd_fifo and awarp_back.
module affine_warp_sampler_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    awarp_req_if.sink                      item,
    awarp_res_if.source                    result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [awarp_pkg::PADDR_W-1:0]  paddr,
    input  logic [awarp_pkg::PDATA_W-1:0]  pwdata,
    output logic [awarp_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import awarp_pkg::*;

    logic [PDATA_W-1:0] c00_reg, c01_reg, c10_reg, c11_reg, off_r_reg, off_c_reg;
    logic               mode_reg;
    logic [PDATA_W-1:0] extent_reg;
    logic               cfg_wr;
    reg_idx_t           reg_sel;
    cfg_t               cfg;

    logic               push_valid, head_valid, pop;
    warp_cmd_t          push_cmd, head_cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c00_reg    <= 32'h0001_0000;
            c01_reg    <= '0;
            c10_reg    <= '0;
            c11_reg    <= 32'h0001_0000;
            off_r_reg  <= '0;
            off_c_reg  <= '0;
            mode_reg   <= MODE_NEAREST;
            extent_reg <= 32'h0200_0200;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_C00:    c00_reg    <= pwdata;
                REG_C01:    c01_reg    <= pwdata;
                REG_C10:    c10_reg    <= pwdata;
                REG_C11:    c11_reg    <= pwdata;
                REG_OFF_R:  off_r_reg  <= pwdata;
                REG_OFF_C:  off_c_reg  <= pwdata;
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_EXTENT: extent_reg <= pwdata;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_C00:    prdata = c00_reg;
            REG_C01:    prdata = c01_reg;
            REG_C10:    prdata = c10_reg;
            REG_C11:    prdata = c11_reg;
            REG_OFF_R:  prdata = off_r_reg;
            REG_OFF_C:  prdata = off_c_reg;
            REG_MODE:   prdata = {{(PDATA_W-1){1'b0}}, mode_reg};
            REG_EXTENT: prdata = extent_reg;
            default:    prdata = '0;
        endcase

        cfg       = '0;
        cfg.c00   = c00_reg;
        cfg.c01   = c01_reg;
        cfg.c10   = c10_reg;
        cfg.c11   = c11_reg;
        cfg.off_r = off_r_reg;
        cfg.off_c = off_c_reg;
        cfg.mode  = mode_t'(mode_reg);
        // Oversized extents saturate at the store size.
        cfg.rows  = (extent_reg[31:16] > 16'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                        : ROWS_W'(extent_reg[31:16]);
        cfg.cols  = (extent_reg[15:0] > 16'(MAX_COLS)) ? COLS_W'(MAX_COLS)
                                                       : COLS_W'(extent_reg[15:0]);
    end

    awarp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .pop        (pop)
    );

    awarp_cmd_fifo u_cmd_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    awarp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .result     (result)
    );

endmodule

>>> sv/awarp_front.sv
// Front end: accepts items, maps request coordinates and classifies them into commands.
// Depends on awarp_pkg and awarp_req_if.
module awarp_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    awarp_req_if.sink             item,
    input  awarp_pkg::cfg_t       cfg,
    output logic                  push_valid,
    output awarp_pkg::warp_cmd_t  push_cmd,
    input  logic                  pop
);
    import awarp_pkg::*;

    localparam int USED_W = $clog2(CMD_DEPTH + 1);
    localparam int HI_W   = SUM_W - FRAC_W;

    logic                     accept;
    logic [USED_W-1:0]        used_reg;
    logic [USED_W-1:0]        used_next;

    logic                     s1_valid_reg;
    logic                     s1_func_reg;
    logic [PIX_W-1:0]         s1_row_reg;
    logic [PIX_W-1:0]         s1_col_reg;
    logic [VAL_W-1:0]         s1_data_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_cr_reg, p_rc_reg, p_cc_reg;

    logic                     s2_valid_reg;
    logic                     s2_func_reg;
    logic [PIX_W-1:0]         s2_row_reg;
    logic [PIX_W-1:0]         s2_col_reg;
    logic [VAL_W-1:0]         s2_data_reg;
    logic signed [SUM_W-1:0]  sr_reg, sc_reg;

    logic signed [SUM_W-1:0]  rnd_r, rnd_c;
    logic [HI_W-1:0]          nr_hi, nc_hi;
    logic                     near_ok_r, near_ok_c, bil_ok_r, bil_ok_c;
    logic [ROW_W-1:0]         bil_r1;
    logic [COL_W-1:0]         bil_c1;

    assign item.ready = (used_reg < USED_W'(CMD_DEPTH));
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        used_next = used_reg + USED_W'(accept) - USED_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_func_reg <= item.func;
        s1_row_reg  <= item.pix_row;
        s1_col_reg  <= item.pix_col;
        s1_data_reg <= item.write_value;
        p_rr_reg    <= $signed({1'b0, item.pix_row}) * cfg.c00;
        p_cr_reg    <= $signed({1'b0, item.pix_col}) * cfg.c10;
        p_rc_reg    <= $signed({1'b0, item.pix_row}) * cfg.c01;
        p_cc_reg    <= $signed({1'b0, item.pix_col}) * cfg.c11;

        s2_func_reg <= s1_func_reg;
        s2_row_reg  <= s1_row_reg;
        s2_col_reg  <= s1_col_reg;
        s2_data_reg <= s1_data_reg;
        sr_reg      <= SUM_W'(p_rr_reg) + SUM_W'(p_cr_reg) + SUM_W'(cfg.off_r);
        sc_reg      <= SUM_W'(p_rc_reg) + SUM_W'(p_cc_reg) + SUM_W'(cfg.off_c);
    end

    // Rounding adds one half and floors: a negative value above -0.5 still rounds to row zero.
    always_comb
    begin
        rnd_r     = sr_reg + SUM_W'(32768);
        rnd_c     = sc_reg + SUM_W'(32768);
        nr_hi     = rnd_r[SUM_W-1:FRAC_W];
        nc_hi     = rnd_c[SUM_W-1:FRAC_W];
        bil_ok_r  = !sr_reg[SUM_W-1] && (nr_hi < HI_W'(cfg.rows));
        bil_ok_c  = !sc_reg[SUM_W-1] && (nc_hi < HI_W'(cfg.cols));
        near_ok_r = sr_reg[SUM_W-1] ? ((sr_reg > -SUM_W'(32768)) && (cfg.rows != '0))
                                    : (nr_hi < HI_W'(cfg.rows));
        near_ok_c = sc_reg[SUM_W-1] ? ((sc_reg > -SUM_W'(32768)) && (cfg.cols != '0))
                                    : (nc_hi < HI_W'(cfg.cols));
        bil_r1    = sr_reg[FRAC_W+ROW_W-1:FRAC_W];
        bil_c1    = sc_reg[FRAC_W+COL_W-1:FRAC_W];

        push_valid       = s2_valid_reg;
        push_cmd         = '0;
        push_cmd.is_write = (s2_func_reg == FUNC_WRITE);
        push_cmd.wr_data = s2_data_reg;
        if (s2_func_reg == FUNC_WRITE)
        begin
            push_cmd.wr_en = ((PIX_W+1)'(s2_row_reg) < (PIX_W+1)'(MAX_ROWS))
                          && ((PIX_W+1)'(s2_col_reg) < (PIX_W+1)'(MAX_COLS));
            push_cmd.row   = s2_row_reg[ROW_W-1:0];
            push_cmd.col   = s2_col_reg[COL_W-1:0];
        end
        else if (cfg.mode == MODE_NEAREST)
        begin
            // Nearest is bilinear with zero fractions and both neighbors folded onto one.
            push_cmd.in_frame = near_ok_r && near_ok_c;
            push_cmd.row     = sr_reg[SUM_W-1] ? '0 : nr_hi[ROW_W-1:0];
            push_cmd.col     = sc_reg[SUM_W-1] ? '0 : nc_hi[COL_W-1:0];
            push_cmd.clamp_r = 1'b1;
            push_cmd.clamp_c = 1'b1;
        end
        else
        begin
            push_cmd.in_frame = bil_ok_r && bil_ok_c;
            push_cmd.row     = bil_r1;
            push_cmd.col     = bil_c1;
            push_cmd.frac_r  = sr_reg[FRAC_W-1:0];
            push_cmd.frac_c  = sc_reg[FRAC_W-1:0];
            push_cmd.clamp_r = ((ROW_W+1)'(bil_r1) + (ROW_W+1)'(1)) >= (ROW_W+1)'(cfg.rows);
            push_cmd.clamp_c = ((COL_W+1)'(bil_c1) + (COL_W+1)'(1)) >= (COL_W+1)'(cfg.cols);
        end
    end

endmodule

>>> sv/awarp_cmd_fifo.sv
// Short command queue between the front end and the sampling back end.
// Depends on awarp_pkg.
module awarp_cmd_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  awarp_pkg::warp_cmd_t  push_cmd,
    output logic                  head_valid,
    output awarp_pkg::warp_cmd_t  head_cmd,
    input  logic                  pop
);
    import awarp_pkg::*;

    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    warp_cmd_t          entry_reg [CMD_DEPTH];
    logic [CMD_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMD_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMD_AW'(1);
            end
            count_reg <= count_reg + CNT_W'(push_valid) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/awarp_back.sv
// Back end: four parity-banked frame memories, bilinear blend and the result queue.
// Depends on awarp_pkg and awarp_res_if.
module awarp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  awarp_pkg::warp_cmd_t  head_cmd,
    output logic                  pop,
    awarp_res_if.source           result
);
    import awarp_pkg::*;

    localparam int USED_W = $clog2(OUT_DEPTH + 1);
    localparam int RES_W  = VAL_W + 1;

    logic [USED_W-1:0]  used_reg;
    logic               res_take;
    logic               issue_sample;

    logic [3:0]         bank_we;
    logic [BANK_AW-1:0] bank_waddr;
    logic [BANK_AW-1:0] bank_raddr [4];
    logic [VAL_W-1:0]   bank_q     [4];
    logic [ROW_W-1:0]   row_sel;
    logic [COL_W-1:0]   col_sel;

    logic               b1_valid_reg;
    logic               b1_inside_reg, b1_rp_reg, b1_cp_reg, b1_clr_reg, b1_clc_reg;
    logic [FRAC_W-1:0]  b1_fr_reg, b1_fc_reg;

    logic [VAL_W-1:0]   p11, p21, p12, p22;
    logic [WGT_W-1:0]   w_r1, w_c1;
    logic [MIX_W-1:0]   mix1, mix2, mix_out;

    logic               b2_valid_reg, b2_inside_reg;
    logic [FRAC_W-1:0]  b2_fc_reg;
    logic [VAL_W-1:0]   i1_reg, i2_reg;

    logic [RES_W-1:0]   res_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]  res_wr_reg, res_rd_reg;
    logic [USED_W-1:0]  res_cnt_reg;
    logic [VAL_W-1:0]   res_value;

    // Credits cover every sample from issue until its result beat leaves.
    assign pop          = head_valid && (head_cmd.is_write || (used_reg < USED_W'(OUT_DEPTH)));
    assign issue_sample = pop && !head_cmd.is_write;
    assign res_take     = result.valid && result.ready;

    always_comb
    begin
        bank_waddr = {head_cmd.row[ROW_W-1:1], head_cmd.col[COL_W-1:1]};
        for (int b = 0; b < 4; b++)
        begin
            row_sel = (head_cmd.row[0] == 1'(b >> 1)) ? head_cmd.row
                                                     : head_cmd.row + ROW_W'(1);
            col_sel = (head_cmd.col[0] == 1'(b)) ? head_cmd.col
                                                : head_cmd.col + COL_W'(1);
            bank_raddr[b] = {row_sel[ROW_W-1:1], col_sel[COL_W-1:1]};
            bank_we[b]    = pop && head_cmd.is_write && head_cmd.wr_en
                         && ({head_cmd.row[0], head_cmd.col[0]} == 2'(b));
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic [VAL_W-1:0] mem [2**BANK_AW];

        always_ff @(posedge clk)
        begin
            if (bank_we[g])
            begin
                mem[bank_waddr] <= head_cmd.wr_data;
            end
            if (issue_sample)
            begin
                bank_q[g] <= mem[bank_raddr[g]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            res_wr_reg   <= '0;
            res_rd_reg   <= '0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            used_reg     <= used_reg + USED_W'(issue_sample) - USED_W'(res_take);
            b1_valid_reg <= issue_sample;
            b2_valid_reg <= b1_valid_reg;
            if (b2_valid_reg)
            begin
                res_wr_reg <= res_wr_reg + OUT_AW'(1);
            end
            if (res_take)
            begin
                res_rd_reg <= res_rd_reg + OUT_AW'(1);
            end
            res_cnt_reg <= res_cnt_reg + USED_W'(b2_valid_reg) - USED_W'(res_take);
        end
    end

    // A clamped axis reuses the first neighbor, which makes its blend exact.
    always_comb
    begin
        p11  = bank_q[{b1_rp_reg, b1_cp_reg}];
        p21  = b1_clr_reg ? p11 : bank_q[{~b1_rp_reg, b1_cp_reg}];
        p12  = b1_clc_reg ? p11 : bank_q[{b1_rp_reg, ~b1_cp_reg}];
        p22  = b1_clr_reg ? p12 : (b1_clc_reg ? p21 : bank_q[{~b1_rp_reg, ~b1_cp_reg}]);
        w_r1 = {1'b1, {FRAC_W{1'b0}}} - WGT_W'(b1_fr_reg);
        mix1 = MIX_W'(b1_fr_reg) * MIX_W'(p21) + MIX_W'(w_r1) * MIX_W'(p11);
        mix2 = MIX_W'(b1_fr_reg) * MIX_W'(p22) + MIX_W'(w_r1) * MIX_W'(p12);

        w_c1    = {1'b1, {FRAC_W{1'b0}}} - WGT_W'(b2_fc_reg);
        mix_out = MIX_W'(w_c1) * MIX_W'(i1_reg) + MIX_W'(b2_fc_reg) * MIX_W'(i2_reg);
        res_value = b2_inside_reg ? mix_out[FRAC_W+VAL_W-1:FRAC_W] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (issue_sample)
        begin
            b1_inside_reg <= head_cmd.in_frame;
            b1_rp_reg     <= head_cmd.row[0];
            b1_cp_reg     <= head_cmd.col[0];
            b1_clr_reg    <= head_cmd.clamp_r;
            b1_clc_reg    <= head_cmd.clamp_c;
            b1_fr_reg     <= head_cmd.frac_r;
            b1_fc_reg     <= head_cmd.frac_c;
        end
        b2_inside_reg <= b1_inside_reg;
        b2_fc_reg     <= b1_fc_reg;
        i1_reg        <= mix1[FRAC_W+VAL_W-1:FRAC_W];
        i2_reg        <= mix2[FRAC_W+VAL_W-1:FRAC_W];
        if (b2_valid_reg)
        begin
            res_mem_reg[res_wr_reg] <= {res_value, b2_inside_reg};
        end
    end

    assign result.valid      = (res_cnt_reg != '0);
    assign result.out_value  = res_mem_reg[res_rd_reg][RES_W-1:1];
    assign result.inside_res = res_mem_reg[res_rd_reg][0];

endmodule

>>> sv/awarp_checker.sv
// Port-level checker for the affine warp sampler, bound to the top level.
// Depends on awarp_pkg and affine_warp_sampler_unit_macros.svh.
`include "affine_warp_sampler_unit_macros.svh"

module awarp_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [awarp_pkg::VAL_W-1:0]    res_value,
    input logic                           res_inside,
    input logic                           psel,
    input logic                           pwrite,
    input logic [awarp_pkg::PADDR_W-1:0]  paddr,
    input logic [awarp_pkg::PDATA_W-1:0]  prdata,
    input logic                           pready
);
    import awarp_pkg::*;

    // A point outside the frame must come back as a zero intensity.
    `AWS_ASSERT_NOW(a_outside_zero, clk, rst_n, res_valid && !res_inside, res_value == '0)

    `AWS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_inside))

    `AWS_ASSERT_NOW(a_pready_high, clk, rst_n, psel, pready)

    // The mode register reads back a single bit.
    `AWS_ASSERT_NOW(a_mode_read, clk, rst_n, psel && !pwrite && (paddr[PADDR_W-1:2] == REG_MODE), prdata[PDATA_W-1:1] == '0)

endmodule

bind affine_warp_sampler_unit awarp_checker u_awarp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_value  (result.out_value),
    .res_inside (result.inside_res),
    .psel       (psel),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .prdata     (prdata),
    .pready     (pready)
);
